>>> rtl/core/mam_pkg.sv
`timescale 1ns / 1ps
// types, codes and widths shared by the matrix add and multiply block
// no dependencies

package mam_pkg;

    localparam int DIM_W  = 3;
    localparam int CNT_W  = 5;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_ROWS_FIRST  = 2'd0;
    localparam logic [1:0] REG_COLS_FIRST  = 2'd1;
    localparam logic [1:0] REG_ROWS_SECOND = 2'd2;
    localparam logic [1:0] REG_COLS_SECOND = 2'd3;

    localparam logic [1:0] KIND_SUM    = 2'd0;
    localparam logic [1:0] KIND_PROD   = 2'd1;
    localparam logic [1:0] KIND_NO_ADD = 2'd2;
    localparam logic [1:0] KIND_NO_MUL = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM_RD,
        S_SUM_EMIT,
        S_NO_ADD,
        S_MUL_RD,
        S_MUL_MUL,
        S_MUL_ACC,
        S_MUL_EMIT,
        S_NO_MUL
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] ra;
        logic [DIM_W-1:0] ca;
        logic [DIM_W-1:0] rb;
        logic [DIM_W-1:0] cb;
    } seq_cmd_t;

endpackage

>>> rtl/core/mam_ram.sv
`timescale 1ns / 1ps
// element store: one write port, one registered read port
// no dependencies

module mam_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/mam_seq.sv
`timescale 1ns / 1ps
// sequencer: walks both stores, forms sums and dot products, drives result register
// depends on mam_pkg

module mam_seq
    import mam_pkg::*;
#(
    parameter int MAX_DIM = 4,
    parameter int AW      = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  seq_cmd_t            cmd,
    output logic                busy,
    output logic                rd_en,
    output logic [AW-1:0]       addr_a,
    output logic [AW-1:0]       addr_b,
    input  logic [DATA_W-1:0]   data_a,
    input  logic [DATA_W-1:0]   data_b,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // row[1:0], col[3:2], value[35:4], zero pad
    output logic [1:0]          m_axis_tuser,   // result_kind[1:0]
    output logic                m_axis_tlast
);

    localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    seq_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [DATA_W-1:0]  acc_reg, acc_next;
    logic [DATA_W-1:0]  prod_reg, prod_next;
    logic [DIM_W-1:0]   ra_reg, ca_reg, rb_reg, cb_reg;

    logic               valid_reg, valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [1:0]         row_reg, row_next;
    logic [1:0]         col_reg, col_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic               last_reg, last_next;
    logic               load_out;

    logic               can_load;
    logic               add_ok, mul_ok;
    logic               i_end_a, j_end_a, i_end_p, j_end_p, k_end;

    assign can_load = !valid_reg || m_axis_tready;
    assign add_ok   = (ra_reg == rb_reg) && (ca_reg == cb_reg);
    assign mul_ok   = (ca_reg == rb_reg);
    assign i_end_a  = (DIM_W'(i_reg) == ra_reg - DIM_W'(1));
    assign j_end_a  = (DIM_W'(j_reg) == ca_reg - DIM_W'(1));
    assign i_end_p  = i_end_a;
    assign j_end_p  = (DIM_W'(j_reg) == cb_reg - DIM_W'(1));
    assign k_end    = (DIM_W'(k_reg) == ca_reg - DIM_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        if (cmd.start && state_reg == S_IDLE)
        begin
            ra_reg <= cmd.ra;
            ca_reg <= cmd.ca;
            rb_reg <= cmd.rb;
            cb_reg <= cmd.cb;
        end
        if (load_out)
        begin
            kind_reg  <= kind_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            value_reg <= value_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        rd_en      = 1'b0;
        addr_a     = '0;
        addr_b     = '0;
        load_out   = 1'b0;
        kind_next  = KIND_SUM;
        row_next   = 2'd0;
        col_next   = 2'd0;
        value_next = '0;
        last_next  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    i_next   = '0;
                    j_next   = '0;
                    k_next   = '0;
                    acc_next = '0;
                    if ((cmd.ra == cmd.rb) && (cmd.ca == cmd.cb))
                    begin
                        state_next = S_SUM_RD;
                    end
                    else
                    begin
                        state_next = S_NO_ADD;
                    end
                end
            end
            S_SUM_RD:
            begin
                rd_en      = 1'b1;
                addr_a     = AW'(i_reg) * AW'(ca_reg) + AW'(j_reg);
                addr_b     = addr_a;
                state_next = S_SUM_EMIT;
            end
            S_SUM_EMIT:
            begin
                if (can_load)
                begin
                    load_out   = 1'b1;
                    kind_next  = KIND_SUM;
                    row_next   = 2'(i_reg);
                    col_next   = 2'(j_reg);
                    value_next = data_a + data_b;
                    state_next = S_SUM_RD;
                    if (j_end_a)
                    begin
                        j_next = '0;
                        if (i_end_a)
                        begin
                            i_next     = '0;
                            state_next = mul_ok ? S_MUL_RD : S_NO_MUL;
                        end
                        else
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            S_NO_ADD:
            begin
                if (can_load)
                begin
                    load_out   = 1'b1;
                    kind_next  = KIND_NO_ADD;
                    state_next = mul_ok ? S_MUL_RD : S_NO_MUL;
                end
            end
            S_MUL_RD:
            begin
                rd_en      = 1'b1;
                addr_a     = AW'(i_reg) * AW'(ca_reg) + AW'(k_reg);
                addr_b     = AW'(k_reg) * AW'(cb_reg) + AW'(j_reg);
                state_next = S_MUL_MUL;
            end
            S_MUL_MUL:
            begin
                prod_next  = data_a * data_b;
                state_next = S_MUL_ACC;
            end
            S_MUL_ACC:
            begin
                acc_next = acc_reg + prod_reg;
                if (k_end)
                begin
                    k_next     = '0;
                    state_next = S_MUL_EMIT;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_MUL_RD;
                end
            end
            S_MUL_EMIT:
            begin
                if (can_load)
                begin
                    load_out   = 1'b1;
                    kind_next  = KIND_PROD;
                    row_next   = 2'(i_reg);
                    col_next   = 2'(j_reg);
                    value_next = acc_reg;
                    last_next  = i_end_p && j_end_p;
                    acc_next   = '0;
                    state_next = S_MUL_RD;
                    if (j_end_p)
                    begin
                        j_next = '0;
                        if (i_end_p)
                        begin
                            i_next     = '0;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            S_NO_MUL:
            begin
                if (can_load)
                begin
                    load_out   = 1'b1;
                    kind_next  = KIND_NO_MUL;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0000, value_reg, col_reg, row_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

endmodule

>>> rtl/core/matrix_add_and_multiply.sv
`timescale 1ns / 1ps
// top level: configuration registers, element loading, stores and sequencer
// depends on mam_pkg, mam_ram, mam_seq

// Loads the elements of matrices A and B (tuser picks the matrix, row-major order) into two
// element stores at one beat per cycle. The beat that completes both matrices starts the
// result walk, during which no input is taken: each sum element is one read of both stores,
// then the add; each product element is a read, multiply and accumulate per column of A, then
// the emit, set by the single read port of each store and the one shared multiply-accumulate
// step. A stalled result beat holds the walk. The stores need no clearing after reset. The user
// must write shape registers over APB only while no job is in progress; the block has no check.

module matrix_add_and_multiply
    import mam_pkg::*;
#(
    parameter int MAX_DIM = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // element[31:0]
    input  logic                s_axis_tuser,   // kind[0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // row[1:0], col[3:2], value[35:4], zero pad
    output logic [1:0]          m_axis_tuser,   // result_kind[1:0]
    output logic                m_axis_tlast
);

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    logic [DIM_W-1:0]   rows_first_reg, cols_first_reg, rows_second_reg, cols_second_reg;
    logic [CNT_W-1:0]   cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]   cnt_b_reg, cnt_b_next;
    logic [DIM_W-1:0]   ra, ca, rb, cb;
    logic [CNT_W-1:0]   size_a, size_b;
    logic               cfg_wr, beat_in, take_a, take_b, complete;
    logic               busy, rd_en;
    logic [AW-1:0]      addr_a, addr_b;
    logic [DATA_W-1:0]  data_a, data_b;
    seq_cmd_t           cmd;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] vmax);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > vmax)
        begin
            r = vmax;
        end
        return r;
    endfunction

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_first_reg  <= DIM_W'(4);
            cols_first_reg  <= DIM_W'(4);
            rows_second_reg <= DIM_W'(4);
            cols_second_reg <= DIM_W'(4);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_ROWS_FIRST:  rows_first_reg  <= pwdata[DIM_W-1:0];
                REG_COLS_FIRST:  cols_first_reg  <= pwdata[DIM_W-1:0];
                REG_ROWS_SECOND: rows_second_reg <= pwdata[DIM_W-1:0];
                REG_COLS_SECOND: cols_second_reg <= pwdata[DIM_W-1:0];
                default:         rows_first_reg  <= rows_first_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ROWS_FIRST:  prdata = {29'd0, rows_first_reg};
            REG_COLS_FIRST:  prdata = {29'd0, cols_first_reg};
            REG_ROWS_SECOND: prdata = {29'd0, rows_second_reg};
            REG_COLS_SECOND: prdata = {29'd0, cols_second_reg};
            default:         prdata = '0;
        endcase
    end

    assign ra     = clamp_dim(rows_first_reg, DIM_MAX);
    assign ca     = clamp_dim(cols_first_reg, DIM_MAX);
    assign rb     = clamp_dim(rows_second_reg, DIM_MAX);
    assign cb     = clamp_dim(cols_second_reg, DIM_MAX);
    assign size_a = CNT_W'(ra) * CNT_W'(ca);
    assign size_b = CNT_W'(rb) * CNT_W'(cb);

    // loading and completion check
    assign s_axis_tready = !busy;
    assign beat_in       = s_axis_tvalid && s_axis_tready;
    assign take_a        = beat_in && !s_axis_tuser && (cnt_a_reg < size_a);
    assign take_b        = beat_in && s_axis_tuser && (cnt_b_reg < size_b);
    assign cnt_a_next    = cnt_a_reg + CNT_W'(take_a);
    assign cnt_b_next    = cnt_b_reg + CNT_W'(take_b);
    assign complete      = beat_in && (cnt_a_next >= size_a) && (cnt_b_next >= size_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end
        else if (complete)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
        end
    end

    assign cmd.start = complete;
    assign cmd.ra    = ra;
    assign cmd.ca    = ca;
    assign cmd.rb    = rb;
    assign cmd.cb    = cb;

    mam_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (DATA_W)
    ) u_store_a (
        .clk   (clk),
        .we    (take_a),
        .waddr (cnt_a_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .re    (rd_en),
        .raddr (addr_a),
        .rdata (data_a)
    );

    mam_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (DATA_W)
    ) u_store_b (
        .clk   (clk),
        .we    (take_b),
        .waddr (cnt_b_reg[AW-1:0]),
        .wdata (s_axis_tdata),
        .re    (rd_en),
        .raddr (addr_b),
        .rdata (data_b)
    );

    mam_seq #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .busy          (busy),
        .rd_en         (rd_en),
        .addr_a        (addr_a),
        .addr_b        (addr_b),
        .data_a        (data_a),
        .data_b        (data_b),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
